// ===== hw/rtl/porc4_pkg.sv =====
`timescale 1ns / 1ps
package porc4_pkg;

    typedef struct packed {
        logic        mode;
        logic [23:0] object_number;
        logic [15:0] generation_number;
        logic [7:0]  data_byte;
        logic        last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       end_of_object;
    } out_word_t;

    // Status and control between the back end and its hash unit.
    typedef struct packed {
        logic start;
        logic done;
    } md5_ctrl_t;

    localparam logic MODE_BEGIN = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [1:0] CFG_KEY_LEN  = 2'd2;

    localparam logic [4:0] MIN_KEY_LEN     = 5'd5;
    localparam logic [4:0] MAX_KEY_BYTES   = 5'd16;
    localparam logic [4:0] SHORT_KEY_LIMIT = 5'd10;
    localparam logic [4:0] TAIL_BYTES      = 5'd5;
    localparam logic [4:0] DIGEST_BYTES    = 5'd16;
    localparam logic [7:0] PAD_BYTE        = 8'h80;
    localparam logic [7:0] BYTE_MASK       = 8'hFF;

    localparam logic [31:0] MD5_INIT_A = 32'h67452301;
    localparam logic [31:0] MD5_INIT_B = 32'hefcdab89;
    localparam logic [31:0] MD5_INIT_C = 32'h98badcfe;
    localparam logic [31:0] MD5_INIT_D = 32'h10325476;

    function automatic logic [4:0] key_len_sat(input logic [4:0] len);
        logic [4:0] res;
        res = len;
        if (len < MIN_KEY_LEN)
        begin
            res = MIN_KEY_LEN;
        end
        else if (len > MAX_KEY_BYTES)
        begin
            res = MAX_KEY_BYTES;
        end
        return res;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [1:0] rnd, input logic [1:0] sub);
        logic [4:0] s;
        case ({rnd, sub})
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] md5_k(input logic [5:0] n);
        logic [31:0] k;
        case (n)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/pdf_object_rc4_cipher_top.sv =====
`timescale 1ns / 1ps
// Per-object RC4 cipher of the PDF standard security handler.
// Item channel (item_valid/item_ready/item_data) takes one word per item. A begin
// word (mode 0) hashes the file key with the object and generation numbers by
// MD5 and runs the RC4 key schedule; it produces no result. A data word (mode 1)
// produces one result word on the result channel with the ciphered byte.
// Configuration words (cfg_valid/cfg_ready/cfg_index/cfg_data) are always taken
// and must only be sent while the block is idle.
// Sequence: a begin word occupies the back end for the MD5 round loop (an add and
// a rotate step per round), the key schedule at four table accesses per entry on
// the permutation memory (one read port, one write port), and a handoff. A data
// word runs the read-swap-write on that memory, then waits in its emit step while
// the result slot is full; its result is registered there, and the back end takes
// no new word before it is idle again. A queue of QUEUE_DEPTH words sits in front.
// Reset leaves the identity permutation (held by per-entry valid bits), zero
// stream indices, a zero file key and a key length of 5. When the receiver
// stalls the result word holds, the back end waits, and once the queue fills
// item_ready drops.
module pdf_object_rc4_cipher_top
    import porc4_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  in_word_t   item_data,
    output logic       result_valid,
    input  logic       result_ready,
    output out_word_t  result_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic [4:0]  key_len_reg;
    logic        q_valid;
    logic        q_ready;
    in_word_t    q_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= MIN_KEY_LEN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LEN:  key_len_reg  <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    porc4_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_word     (q_word)
    );

    porc4_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_word       (q_word),
        .file_key     ({key_high_reg, key_low_reg}),
        .key_len      (key_len_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

// ===== hw/rtl/porc4_front.sv =====
`timescale 1ns / 1ps
module porc4_front
    import porc4_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  in_word_t item_data,
    output logic     q_valid,
    input  logic     q_ready,
    output in_word_t q_word
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    in_word_t        fifo_mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    in_word_t        clean_word;
    logic            push;
    logic            pop;

    // Fields that the mode does not use are cleared, so the back end sees one shape per kind.
    always_comb
    begin
        clean_word = item_data;
        if (item_data.mode == MODE_BEGIN)
        begin
            clean_word.data_byte = '0;
            clean_word.last_byte = 1'b0;
        end
        else
        begin
            clean_word.object_number     = '0;
            clean_word.generation_number = '0;
        end
    end

    assign item_ready = (count_reg != CW'(DEPTH));
    assign q_valid    = (count_reg != '0);
    assign q_word     = fifo_mem[rd_ptr_reg];
    assign push       = item_valid && item_ready;
    assign pop        = q_valid && q_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= clean_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow the queue");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

// ===== hw/rtl/porc4_md5.sv =====
`timescale 1ns / 1ps
module porc4_md5
    import porc4_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  md5_ctrl_t    ctrl_in,
    output md5_ctrl_t    ctrl_out,
    input  logic [511:0] msg,
    output logic [127:0] digest
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_ADD  = 2'd1;
    localparam logic [1:0] M_ROT  = 2'd2;
    localparam logic [1:0] M_FIN  = 2'd3;

    logic [1:0]   state_reg;
    logic [5:0]   n_reg;
    logic         done_reg;
    logic [511:0] msg_reg;
    logic [31:0]  a_reg;
    logic [31:0]  b_reg;
    logic [31:0]  c_reg;
    logic [31:0]  d_reg;
    logic [31:0]  t_reg;
    logic [31:0]  t_next;
    logic [31:0]  f;
    logic [3:0]   g;
    logic [31:0]  w;
    logic [4:0]   s;
    logic [63:0]  dbl;

    always_comb
    begin
        case (n_reg[5:4])
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = n_reg[3:0];
            end
            2'd1:
            begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = 4'(n_reg * 3'd5 + 1'b1);
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(n_reg * 2'd3 + 3'd5);
            end
            default:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(n_reg * 3'd7);
            end
        endcase
        w      = msg_reg[32*g +: 32];
        t_next = a_reg + f + md5_k(n_reg) + w;
        s      = md5_rot(n_reg[5:4], n_reg[1:0]);
        dbl    = {t_reg, t_reg} << s;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                if (ctrl_in.start)
                begin
                    msg_reg <= msg;
                    a_reg   <= MD5_INIT_A;
                    b_reg   <= MD5_INIT_B;
                    c_reg   <= MD5_INIT_C;
                    d_reg   <= MD5_INIT_D;
                end
            end
            M_ADD:
            begin
                t_reg <= t_next;
            end
            M_ROT:
            begin
                a_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= b_reg;
                b_reg <= b_reg + dbl[63:32];
            end
            M_FIN:
            begin
                digest <= {MD5_INIT_D + d_reg, MD5_INIT_C + c_reg,
                           MD5_INIT_B + b_reg, MD5_INIT_A + a_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            n_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (ctrl_in.start)
                    begin
                        n_reg     <= '0;
                        state_reg <= M_ADD;
                    end
                end
                M_ADD:
                begin
                    state_reg <= M_ROT;
                end
                M_ROT:
                begin
                    n_reg     <= n_reg + 1'b1;
                    state_reg <= (n_reg == 6'd63) ? M_FIN : M_ADD;
                end
                M_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign ctrl_out.start = 1'b0;
    assign ctrl_out.done  = done_reg;

endmodule

// ===== hw/rtl/porc4_back.sv =====
`timescale 1ns / 1ps
module porc4_back
    import porc4_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    output logic         q_ready,
    input  in_word_t     q_word,
    input  logic [127:0] file_key,
    input  logic [4:0]   key_len,
    output logic         result_valid,
    input  logic         result_ready,
    output out_word_t    result_data
);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_MD5  = 4'd1;
    localparam logic [3:0] B_K1   = 4'd2;
    localparam logic [3:0] B_K2   = 4'd3;
    localparam logic [3:0] B_K3   = 4'd4;
    localparam logic [3:0] B_K4   = 4'd5;
    localparam logic [3:0] B_P1   = 4'd6;
    localparam logic [3:0] B_P2   = 4'd7;
    localparam logic [3:0] B_P3   = 4'd8;
    localparam logic [3:0] B_EMIT = 4'd9;

    logic [3:0]   state_reg;
    logic [3:0]   state_next;
    logic [7:0]   i_reg;
    logic [7:0]   j_reg;
    logic [7:0]   n_reg;
    logic [3:0]   kidx_reg;
    logic [7:0]   s_reg;
    logic [7:0]   sj_reg;
    logic [7:0]   data_reg;
    logic         last_reg;
    out_word_t    res_reg;
    logic         result_valid_reg;
    out_word_t    result_data_reg;

    logic [7:0]   perm_mem [256];
    logic [255:0] valid_reg;
    logic [7:0]   rd_reg;
    logic         rvalid_reg;
    logic [7:0]   raddr_reg;
    logic [7:0]   raddr;
    logic [7:0]   waddr;
    logic [7:0]   wdata;
    logic         we;
    logic         tbl_clear;
    logic [7:0]   eff;
    logic [7:0]   ks;
    logic [7:0]   j_sum;
    logic [7:0]   key_byte;
    logic [4:0]   len_sat;
    logic [4:0]   klen;
    logic [511:0] msg;
    logic [39:0]  tail;
    logic [2:0]   tail_idx;
    logic [6:0]   pidx;
    md5_ctrl_t    md5_in;
    md5_ctrl_t    md5_out;
    logic [127:0] digest;

    // An entry never written since the last clear holds its own index.
    assign eff      = rvalid_reg ? rd_reg : raddr_reg;
    assign key_byte = digest[8*kidx_reg +: 8];
    assign j_sum    = j_reg + eff + key_byte;
    assign len_sat  = key_len_sat(key_len);
    assign klen     = (len_sat > SHORT_KEY_LIMIT) ? DIGEST_BYTES : len_sat + TAIL_BYTES;
    assign tail     = {q_word.generation_number, q_word.object_number};

    // One message block: key bytes, object and generation bytes, pad, bit length.
    always_comb
    begin
        msg      = '0;
        tail_idx = '0;
        for (int p = 0; p < 64; p++)
        begin
            pidx     = 7'(p);
            tail_idx = 3'(pidx - {2'b00, len_sat});
            if (pidx < {2'b00, len_sat})
            begin
                msg[8*p +: 8] = file_key[8*(p % 16) +: 8];
            end
            else if (pidx < {2'b00, len_sat} + {2'b00, TAIL_BYTES})
            begin
                msg[8*p +: 8] = tail[8*tail_idx +: 8];
            end
            else if (pidx == {2'b00, len_sat} + {2'b00, TAIL_BYTES})
            begin
                msg[8*p +: 8] = PAD_BYTE;
            end
            else if (p == 56)
            begin
                msg[8*p +: 8] = {len_sat + TAIL_BYTES, 3'b000};
            end
        end
    end

    // Keystream byte: the two table writes of this step are not yet visible to the read.
    always_comb
    begin
        if (raddr_reg == j_reg)
        begin
            ks = s_reg;
        end
        else if (raddr_reg == i_reg)
        begin
            ks = sj_reg;
        end
        else
        begin
            ks = eff;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        q_ready      = 1'b0;
        md5_in.start = 1'b0;
        md5_in.done  = 1'b0;
        tbl_clear    = 1'b0;
        we           = 1'b0;
        waddr        = '0;
        wdata        = '0;
        raddr        = '0;
        case (state_reg)
            B_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    if (q_word.mode == MODE_BEGIN)
                    begin
                        md5_in.start = 1'b1;
                        state_next   = B_MD5;
                    end
                    else
                    begin
                        raddr      = i_reg + 1'b1;
                        state_next = B_P1;
                    end
                end
            end
            B_MD5:
            begin
                if (md5_out.done)
                begin
                    tbl_clear  = 1'b1;
                    state_next = B_K1;
                end
            end
            B_K1:
            begin
                raddr      = n_reg;
                state_next = B_K2;
            end
            B_K2:
            begin
                raddr      = j_sum;
                state_next = B_K3;
            end
            B_K3:
            begin
                we         = 1'b1;
                waddr      = n_reg;
                wdata      = eff;
                state_next = B_K4;
            end
            B_K4:
            begin
                we         = 1'b1;
                waddr      = j_reg;
                wdata      = s_reg;
                state_next = (n_reg == BYTE_MASK) ? B_IDLE : B_K1;
            end
            B_P1:
            begin
                raddr      = j_reg + eff;
                state_next = B_P2;
            end
            B_P2:
            begin
                we         = 1'b1;
                waddr      = i_reg;
                wdata      = eff;
                raddr      = s_reg + eff;
                state_next = B_P3;
            end
            B_P3:
            begin
                we         = 1'b1;
                waddr      = j_reg;
                wdata      = s_reg;
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    porc4_md5 u_md5 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (md5_in),
        .ctrl_out (md5_out),
        .msg      (msg),
        .digest   (digest)
    );

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            perm_mem[waddr] <= wdata;
        end
        rd_reg     <= perm_mem[raddr];
        rvalid_reg <= valid_reg[raddr];
        raddr_reg  <= raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (tbl_clear)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                data_reg <= q_word.data_byte;
                last_reg <= q_word.last_byte;
            end
            B_K2, B_P1:
            begin
                s_reg <= eff;
            end
            B_P2:
            begin
                sj_reg <= eff;
            end
            B_P3:
            begin
                res_reg.cipher_byte   <= data_reg ^ ks;
                res_reg.end_of_object <= last_reg;
            end
            default:
            begin
            end
        endcase
        if (state_reg == B_EMIT && (!result_valid_reg || result_ready))
        begin
            result_data_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            i_reg            <= '0;
            j_reg            <= '0;
            n_reg            <= '0;
            kidx_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid && q_word.mode == MODE_DATA)
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                B_MD5:
                begin
                    n_reg    <= '0;
                    j_reg    <= '0;
                    kidx_reg <= '0;
                end
                B_K2:
                begin
                    j_reg <= j_sum;
                end
                B_K4:
                begin
                    n_reg    <= n_reg + 1'b1;
                    kidx_reg <= ({1'b0, kidx_reg} == klen - 1'b1) ? '0 : kidx_reg + 1'b1;
                    if (n_reg == BYTE_MASK)
                    begin
                        i_reg <= '0;
                        j_reg <= '0;
                    end
                end
                B_P1:
                begin
                    j_reg <= j_reg + eff;
                end
                default:
                begin
                end
            endcase
            if (state_reg == B_EMIT && (!result_valid_reg || result_ready))
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    a_ksa_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_K4 && n_reg == BYTE_MASK) |=> (i_reg == 8'h00 && j_reg == 8'h00))
        else $error("stream indices not cleared after key schedule");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EMIT && result_valid_reg && !result_ready) |=> (state_reg == B_EMIT))
        else $error("result left while output slot busy");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == B_K3 || state_reg == B_K4 || state_reg == B_P2 ||
                state_reg == B_P3))
        else $error("table write outside a write step");

    a_hash_start: assert property (@(posedge clk) disable iff (!rst_n)
        md5_in.start |=> (state_reg == B_MD5))
        else $error("hash started without waiting for it");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import porc4_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;
    // Up to a full queue of begin words plus the one in progress may still be running.
    localparam int BACKEND_SETTLE = 6400;

    class rc4_scoreboard;
        bit [63:0] key_low;
        bit [63:0] key_high;
        bit [4:0] key_len;
        bit [7:0] perm [256];
        bit [7:0] idx_i;
        bit [7:0] idx_j;
        out_word_t cipher_q [$];
        bit [31:0] sine_k [64];
        int unsigned rot [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        int errors;

        function new();
            real v;
            for (int n = 0; n < 64; n++)
            begin
                v = $sin(n + 1);
                if (v < 0.0)
                begin
                    v = -v;
                end
                sine_k[n] = 32'(longint'($floor(v * 4294967296.0)));
            end
            key_low = '0;
            key_high = '0;
            key_len = MIN_KEY_LEN;
            for (int n = 0; n < 256; n++)
            begin
                perm[n] = 8'(n);
            end
            idx_i = '0;
            idx_j = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] index, bit [63:0] value);
            if (index == CFG_KEY_LOW)
            begin
                key_low = value;
            end
            else if (index == CFG_KEY_HIGH)
            begin
                key_high = value;
            end
            else if (index == CFG_KEY_LEN)
            begin
                key_len = value[4:0];
            end
        endfunction

        function void derive_object_key(bit [23:0] obj, bit [15:0] gen);
            bit [7:0] blk [64];
            bit [7:0] okey [16];
            bit [31:0] w [16];
            bit [31:0] iv [4];
            bit [31:0] a, b, c, d, f, t, x, dg [4];
            int len, klen, g, r, bits;
            bit [7:0] j, s;
            iv = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
            len = int'(key_len);
            if (len < 5)
            begin
                len = 5;
            end
            if (len > 16)
            begin
                len = 16;
            end
            for (int n = 0; n < 64; n++)
            begin
                blk[n] = '0;
            end
            for (int n = 0; n < len; n++)
            begin
                blk[n] = (n < 8) ? key_low[8*n +: 8] : key_high[8*(n-8) +: 8];
            end
            blk[len] = obj[7:0];
            blk[len+1] = obj[15:8];
            blk[len+2] = obj[23:16];
            blk[len+3] = gen[7:0];
            blk[len+4] = gen[15:8];
            blk[len+5] = 8'h80;
            bits = (len + 5) * 8;
            blk[56] = bits[7:0];
            blk[57] = bits[15:8];
            for (int n = 0; n < 16; n++)
            begin
                w[n] = {blk[4*n+3], blk[4*n+2], blk[4*n+1], blk[4*n]};
            end
            a = iv[0];
            b = iv[1];
            c = iv[2];
            d = iv[3];
            for (int n = 0; n < 64; n++)
            begin
                r = n / 16;
                case (r)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        g = n;
                    end
                    1:
                    begin
                        f = (d & b) | (~d & c);
                        g = (5*n + 1) % 16;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        g = (3*n + 5) % 16;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        g = (7*n) % 16;
                    end
                endcase
                x = a + f + sine_k[n] + w[g];
                t = d;
                d = c;
                c = b;
                b = b + ((x << rot[4*r + n%4]) | (x >> (32 - rot[4*r + n%4])));
                a = t;
            end
            dg[0] = iv[0] + a;
            dg[1] = iv[1] + b;
            dg[2] = iv[2] + c;
            dg[3] = iv[3] + d;
            for (int n = 0; n < 16; n++)
            begin
                okey[n] = dg[n/4][8*(n%4) +: 8];
            end
            klen = (len > 10) ? 16 : len + 5;
            for (int n = 0; n < 256; n++)
            begin
                perm[n] = 8'(n);
            end
            j = '0;
            for (int n = 0; n < 256; n++)
            begin
                s = perm[n];
                j = j + s + okey[n % klen];
                perm[n] = perm[j];
                perm[j] = s;
            end
            idx_i = '0;
            idx_j = '0;
        endfunction

        function void note_input(in_word_t word);
            bit [7:0] si, sj;
            out_word_t res;
            if (word.mode == MODE_BEGIN)
            begin
                derive_object_key(word.object_number, word.generation_number);
            end
            else
            begin
                idx_i = idx_i + 8'd1;
                si = perm[idx_i];
                idx_j = idx_j + si;
                sj = perm[idx_j];
                perm[idx_i] = sj;
                perm[idx_j] = si;
                res.cipher_byte = word.data_byte ^ perm[8'(si + sj)];
                res.end_of_object = word.last_byte;
                cipher_q.push_back(res);
            end
        endfunction

        task report(string what, int expv, int gotv);
            $display("MISMATCH %s: expected %0h got %0h at %0t", what, expv, gotv, $time);
            errors++;
        endtask

        task check_result(out_word_t got);
            out_word_t want;
            if (cipher_q.size() == 0)
            begin
                report("unexpected word", 0, int'(got));
            end
            else
            begin
                want = cipher_q.pop_front();
                if (got.cipher_byte !== want.cipher_byte)
                begin
                    report("cipher_byte", int'(want.cipher_byte), int'(got.cipher_byte));
                end
                if (got.end_of_object !== want.end_of_object)
                begin
                    report("end_of_object", int'(want.end_of_object),
                           int'(got.end_of_object));
                end
            end
        endtask

        function int pending();
            return cipher_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    in_word_t item_data = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    out_word_t result_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = CFG_KEY_LOW;
    logic [63:0] cfg_data = '0;

    rc4_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int burst_left = 0;
    bit hold_request = 0;

    pdf_object_rc4_cipher_top u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item_data(item_data),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_data(result_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: check accepted words, and stall on a pattern chosen at random, which changes over the run.
    initial
    begin
        int stall_mode;
        int hold_left;
        stall_mode = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                sb.check_result(result_data);
            end
            if (hold_request)
            begin
                hold_request = 0;
                hold_left = 400;
            end
            if (cycle_count % 64 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= ($urandom_range(0, 1) == 1);
                    2: result_ready <= ($urandom_range(0, 3) == 0);
                    default: result_ready <= (cycle_count % 8 < 5);
                endcase
            end
        end
    end

    task send_item(in_word_t word);
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 15);
        end
        item_valid <= 1'b1;
        item_data <= word;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        sb.note_input(word);
        burst_left--;
    endtask

    task send_begin(bit [23:0] obj, bit [15:0] gen);
        in_word_t word;
        word.mode = MODE_BEGIN;
        word.object_number = obj;
        word.generation_number = gen;
        word.data_byte = 8'($urandom);
        word.last_byte = 1'($urandom);
        send_item(word);
    endtask

    task send_data(bit [7:0] data, bit last);
        in_word_t word;
        word.mode = MODE_DATA;
        word.object_number = 24'($urandom);
        word.generation_number = 16'($urandom);
        word.data_byte = data;
        word.last_byte = last;
        send_item(word);
    endtask

    // Stop sending and let the back end finish before touching the registers.
    task wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (BACKEND_SETTLE) @(posedge clk);
    endtask

    task write_reg(logic [1:0] index, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.write_reg(index, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task random_items(int count);
        int sent;
        int n;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                send_begin(24'($urandom), 16'($urandom));
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
                for (int k = 0; k < n; k++)
                begin
                    send_data(8'($urandom), k == n - 1);
                end
                sent += n + 1;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                send_begin(24'($urandom), 16'($urandom));
                sent++;
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                begin
                    send_data(8'($urandom), 1'($urandom));
                end
                sent += n;
            end
        end
    endtask

    initial
    begin
        logic [4:0] lengths [8];
        lengths = '{5'd16, 5'd0, 5'd31, 5'd10, 5'd11, 5'd5, 5'd16, 5'd7};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Data ahead of any begin runs on the identity table.
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b1);
        send_begin(24'h000000, 16'h0000);
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'hA5, 1'b1);
        // The keystream continues past the last byte.
        send_data(8'h5A, 1'b0);
        send_data(8'h3C, 1'b1);
        send_begin(24'hFFFFFF, 16'hFFFF);
        send_data(8'hFF, 1'b0);
        send_data(8'h00, 1'b1);
        send_begin(24'h000001, 16'h0000);
        send_begin(24'h800000, 16'h8000);
        send_data(8'h80, 1'b0);
        send_data(8'h01, 1'b1);
        random_items(90);

        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            write_reg(CFG_KEY_LOW, (p == 0) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                   (p == 5) ? 64'h0 : {$urandom, $urandom});
            write_reg(CFG_KEY_HIGH, (p == 0) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                    (p == 5) ? 64'h0 : {$urandom, $urandom});
            write_reg(CFG_KEY_LEN, {59'd0, lengths[p]});
            if (p == 2)
            begin
                hold_request = 1;
            end
            random_items(190);
        end

        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/porc4_pkg.sv
hw/rtl/porc4_front.sv
hw/rtl/porc4_md5.sv
hw/rtl/porc4_back.sv
hw/rtl/pdf_object_rc4_cipher_top.sv
tb/tb_top.sv
